// File: hw/rtl/accel_limited_approach_core_assert.svh
// assertion macros used by the port-level checker file
`ifndef ACCEL_LIMITED_APPROACH_CORE_ASSERT_SVH
`define ACCEL_LIMITED_APPROACH_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ALA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ala assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ALA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ala assertion failed");

`endif

// File: hw/rtl/ala_pkg.sv
// types and constants of the acceleration-limited approach block
package ala_pkg;

  localparam int PortW   = 32;  // position, velocity and target ports
  localparam int AccW    = 31;  // accelerations and speed limits
  localparam int ErrW    = 34;  // exact error and grown velocity
  localparam int PaddrW  = 3;
  localparam int RegIdxLsb = 2;
  localparam int PdataW  = 32;

  localparam logic [AccW-1:0] AccelRst = AccW'(256);

  typedef enum logic {
    RegAccelPos = 1'b0,
    RegAccelNeg = 1'b1
  } ala_reg_e;

  typedef struct packed {
    logic [AccW-1:0] accel_pos;
    logic [AccW-1:0] accel_neg;
  } ala_cfg_t;

  typedef struct packed {
    logic signed [PortW-1:0] target;
    logic [AccW-1:0]         max_up;
    logic [AccW-1:0]         max_down;
    logic                    snap;
  } ala_item_t;

endpackage

// File: hw/rtl/ala_cfg_regs.sv
// apb register file holding the two acceleration settings
module ala_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ala_pkg::PaddrW-1:0] paddr,
  input  logic [ala_pkg::PdataW-1:0] pwdata,
  output logic [ala_pkg::PdataW-1:0] prdata,
  output logic                       pready,
  output ala_pkg::ala_cfg_t          cfg_o
);
  import ala_pkg::*;

  logic [AccW-1:0] accel_pos_q, accel_neg_q;
  logic            wr_en;
  ala_reg_e        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = ala_reg_e'(paddr[RegIdxLsb]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_pos_q <= AccelRst;
      accel_neg_q <= AccelRst;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegAccelPos: accel_pos_q <= pwdata[AccW-1:0];
        RegAccelNeg: accel_neg_q <= pwdata[AccW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegAccelPos: prdata = PdataW'(accel_pos_q);
      RegAccelNeg: prdata = PdataW'(accel_neg_q);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.accel_pos = accel_pos_q;
  assign cfg_o.accel_neg = accel_neg_q;

endmodule

// File: hw/rtl/ala_step.sv
// one tick of the follower: new velocity and position from state and item
module ala_step #(
  parameter int StateW = 32
) (
  input  ala_pkg::ala_item_t         item_i,
  input  ala_pkg::ala_cfg_t          cfg_i,
  input  logic signed [StateW-1:0]   pos_i,
  input  logic signed [StateW-1:0]   vel_i,
  output logic signed [StateW-1:0]   pos_o,
  output logic signed [StateW-1:0]   vel_o,
  output logic                       arrived_o
);
  import ala_pkg::*;

  localparam longint HiL = (longint'(1) << (StateW - 1)) - 1;
  localparam logic signed [ErrW-1:0] Hi = ErrW'(HiL);
  localparam logic signed [ErrW-1:0] Lo = ErrW'(-HiL - 1);

  function automatic logic signed [StateW-1:0] sat_st(input logic signed [ErrW-1:0] x);
    logic signed [StateW-1:0] r;
    if (x > Hi)      r = Hi[StateW-1:0];
    else if (x < Lo) r = Lo[StateW-1:0];
    else             r = x[StateW-1:0];
    return r;
  endfunction

  logic signed [ErrW-1:0] tgt, pos_x, vel_x, err;
  logic signed [ErrW-1:0] acc_p, acc_n, lim_up, lim_dn;
  logic signed [ErrW-1:0] grown_up, grown_dn, v, sum;
  logic signed [StateW-1:0] vel_sm;

  assign tgt    = ErrW'(item_i.target);
  assign pos_x  = ErrW'(pos_i);
  assign vel_x  = ErrW'(vel_i);
  assign acc_p  = $signed(ErrW'(cfg_i.accel_pos));
  assign acc_n  = $signed(ErrW'(cfg_i.accel_neg));
  assign lim_up = $signed(ErrW'(item_i.max_up));
  assign lim_dn = -$signed(ErrW'(item_i.max_down));

  assign err      = tgt - pos_x;
  assign grown_up = vel_x + acc_p;
  assign grown_dn = vel_x - acc_n;

  always_comb begin
    priority if (err > 0 && vel_x >= 0) begin
      // landing exactly on target wins over the speed limit
      if (grown_up > err)         v = err;
      else if (grown_up > lim_up) v = lim_up;
      else                        v = grown_up;
    end else if (err < 0 && vel_x <= 0) begin
      if (grown_dn < err)         v = err;
      else if (grown_dn < lim_dn) v = lim_dn;
      else                        v = grown_dn;
    end else begin
      v = '0;
    end
  end

  assign vel_sm = sat_st(v);
  assign sum    = pos_x + ErrW'(vel_sm);

  always_comb begin
    if (item_i.snap) begin
      pos_o = sat_st(tgt);
      vel_o = vel_i;
    end else begin
      pos_o = sat_st(sum);
      vel_o = vel_sm;
    end
  end

  assign arrived_o = (ErrW'(pos_o) == tgt);

endmodule

// File: hw/rtl/accel_limited_approach_core.sv
// top level of the acceleration-limited approach block
// One item per clock cycle, sustained while the output side does not
// stall. An accepted beat is held in an input register, one tick of the
// follower runs between it and the result register, which loads when the
// output side does not stall. Position and velocity state are updated in
// the same cycle as the result register, so consecutive beats see each
// other's state with no bubble. State is DATA_WIDTH bits wide (at most 32).
// The two accelerations sit behind an apb port at byte addresses 0 and 4 and
// reset to 256; write them only while no beat is in flight.
module accel_limited_approach_core #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [ala_pkg::PortW-1:0] target_i,
  input  logic [ala_pkg::AccW-1:0]   max_up_i,
  input  logic [ala_pkg::AccW-1:0]   max_down_i,
  input  logic                       snap_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [ala_pkg::PortW-1:0] position_o,
  output logic signed [ala_pkg::PortW-1:0] velocity_o,
  output logic                       arrived_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ala_pkg::PaddrW-1:0] paddr,
  input  logic [ala_pkg::PdataW-1:0] pwdata,
  output logic [ala_pkg::PdataW-1:0] prdata,
  output logic                       pready
);
  import ala_pkg::*;

  localparam int StateW = (DATA_WIDTH > PortW) ? PortW : DATA_WIDTH;

  ala_cfg_t  cfg;
  ala_item_t item_q;
  logic      s1_valid_q, out_valid_q;
  logic      out_free, s1_adv, in_acc;
  logic signed [StateW-1:0] pos_q, vel_q, pos_d, vel_d;
  logic      arrived_d;
  logic signed [PortW-1:0] position_q, velocity_q;
  logic      arrived_q;

  ala_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ala_step #(.StateW(StateW)) u_step (
    .item_i    (item_q),
    .cfg_i     (cfg),
    .pos_i     (pos_q),
    .vel_i     (vel_q),
    .pos_o     (pos_d),
    .vel_o     (vel_d),
    .arrived_o (arrived_d)
  );

  // result register can take a beat when empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      vel_q       <= '0;
    end else begin
      if (in_acc)        s1_valid_q <= 1'b1;
      else if (s1_adv)   s1_valid_q <= 1'b0;
      if (s1_adv)        out_valid_q <= 1'b1;
      else if (out_free) out_valid_q <= 1'b0;
      if (s1_adv) begin
        pos_q <= pos_d;
        vel_q <= vel_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.target   <= target_i;
      item_q.max_up   <= max_up_i;
      item_q.max_down <= max_down_i;
      item_q.snap     <= snap_i;
    end
    if (s1_adv) begin
      position_q <= PortW'(pos_d);
      velocity_q <= PortW'(vel_d);
      arrived_q  <= arrived_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = position_q;
  assign velocity_o  = velocity_q;
  assign arrived_o   = arrived_q;

endmodule

// File: hw/rtl/ala_core_chk.sv
// port-level checker for the approach core, bound to the top level
`include "accel_limited_approach_core_assert.svh"

module ala_core_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic signed [ala_pkg::PortW-1:0] position_o,
  input logic signed [ala_pkg::PortW-1:0] velocity_o,
  input logic                       arrived_o
);

  // a stalled result beat stays put
  `ALA_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(position_o) && $stable(velocity_o) && $stable(arrived_o))

  // input side only stalls behind a blocked result
  `ALA_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

  // an accepted beat reaches the output via the input and result registers without backpressure
  `ALA_ASSERT_NXT(a_latency, (in_valid_i && !in_stall_o) ##1 !out_stall_i, out_valid_o)

endmodule

bind accel_limited_approach_core ala_core_chk u_ala_core_chk (.*);
